// ----- hw/rtl/ebcdic_field_to_ascii_text_assert.svh -----
// assertion macros, empty when synthesizing
`ifndef EBCDIC_FIELD_TO_ASCII_TEXT_ASSERT_SVH
`define EBCDIC_FIELD_TO_ASCII_TEXT_ASSERT_SVH
`ifndef SYNTHESIS
`define E2A_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("e2a assertion failed");
`define E2A_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("e2a assertion failed");
`else
`define E2A_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define E2A_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/e2a_pkg.sv -----
`timescale 1ns / 1ps
package e2a_pkg;
   localparam int CNT_W            = 7;
   localparam int MAX_TEXT         = 35;
   localparam int PACKED_MAX_BYTES = 16;
   localparam int STAMP_BYTES      = 26;

   localparam logic [7:0] ZONE_PLAIN   = 8'hF0;
   localparam logic [7:0] ZONE_MASK    = 8'hF0;
   localparam logic [7:0] ZONE_NEG     = 8'hD0;
   localparam logic [7:0] NIBBLE_MASK  = 8'h0F;
   localparam logic [7:0] SIGN_NEG     = 8'h0D;
   localparam logic [7:0] EBCDIC_BLANK = 8'h40;
   localparam logic [7:0] ASCII_DIGIT  = 8'h30;
   localparam logic [7:0] CH_MINUS     = 8'h2D;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_ZERO      = 8'h30;

   localparam logic [1:0] FT_PACKED = 2'd0;
   localparam logic [1:0] FT_ZONED  = 2'd1;
   localparam logic [1:0] FT_ALPHA  = 2'd2;
   localparam logic [1:0] FT_STAMP  = 2'd3;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_STAMP  = 3'd1;
   localparam logic [2:0] ST_PREC   = 3'd2;
   localparam logic [2:0] ST_COUNT  = 3'd3;
   localparam logic [2:0] ST_PACKED = 3'd4;

   localparam logic [1:0] REG_FIELD_TYPE  = 2'd0;
   localparam logic [1:0] REG_FIELD_BYTES = 2'd1;
   localparam logic [1:0] REG_PRECISION   = 2'd2;

   localparam logic [7:0] LATIN1_OF [256] = '{
      0, 1, 2, 3, 156, 9, 134, 127, 151, 141, 142, 11, 12, 13, 14, 15,
      16, 17, 18, 19, 157, 133, 8, 135, 24, 25, 146, 143, 28, 29, 30, 31,
      128, 129, 130, 131, 132, 10, 23, 27, 136, 137, 138, 139, 140, 5, 6, 7,
      144, 145, 22, 147, 148, 149, 150, 4, 152, 153, 154, 155, 20, 21, 158, 26,
      32, 160, 161, 162, 163, 164, 165, 166, 167, 168, 91, 46, 60, 40, 43, 33,
      38, 169, 170, 171, 172, 173, 174, 175, 176, 177, 93, 36, 42, 41, 59, 94,
      45, 47, 178, 179, 180, 181, 182, 183, 184, 185, 124, 44, 37, 95, 62, 63,
      186, 187, 188, 189, 190, 191, 192, 193, 194, 96, 58, 35, 64, 39, 61, 34,
      195, 97, 98, 99, 100, 101, 102, 103, 104, 105, 196, 197, 198, 199, 200, 201,
      202, 106, 107, 108, 109, 110, 111, 112, 113, 114, 203, 204, 205, 206, 207, 208,
      209, 126, 115, 116, 117, 118, 119, 120, 121, 122, 210, 211, 212, 213, 214, 215,
      216, 217, 218, 219, 220, 221, 222, 223, 224, 225, 226, 227, 228, 229, 230, 231,
      123, 65, 66, 67, 68, 69, 70, 71, 72, 73, 232, 233, 234, 235, 236, 237,
      125, 74, 75, 76, 77, 78, 79, 80, 81, 82, 238, 239, 240, 241, 242, 243,
      92, 159, 83, 84, 85, 86, 87, 88, 89, 90, 244, 245, 246, 247, 248, 249,
      48, 49, 50, 51, 52, 53, 54, 55, 56, 57, 250, 251, 252, 253, 254, 255
   };

   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
   } job_type;

   typedef struct packed {
      logic [1:0] field_type;
      logic [5:0] field_bytes;
      logic [4:0] precision;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic busy;
      logic pop;
   } back_stat_type;
endpackage

// ----- hw/rtl/e2a_chan_if.sv -----
`timescale 1ns / 1ps
interface e2a_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface e2a_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       end_of_text;
   logic       empty_text;
   logic [2:0] status;

   modport source (output valid, output out_char, output end_of_text, output empty_text,
                   output status, input ready);
   modport sink (input valid, input out_char, input end_of_text, input empty_text,
                 input status, output ready);
endinterface

// ----- hw/rtl/ebcdic_field_to_ascii_text.sv -----
`timescale 1ns / 1ps
`include "ebcdic_field_to_ascii_text_assert.svh"
// Converts one record field, delivered as raw bytes with the final byte marked, into
// ASCII text, one character per result word: packed or zoned decimal becomes a signed
// number with zero suppression and a decimal point if precision > 0, alphanumeric fields are blank
// trimmed and translated from EBCDIC to Latin-1, timestamps (26 bytes) are translated.
// A field with a bad length or precision gives a single error word with empty_text set.
// Input bytes are taken one per cycle into one of two field banks; a two-entry job
// queue lets the next field load while the previous one is being converted. With both
// banks full the input stalls. The converter reads the bank through a read state ahead
// of each state that uses the byte. After picking up a field it reads the sign and then
// each digit of a number, adding a minus, point or lone zero where due; for text it reads
// and translates each byte, after trimming trailing blanks for alphanumeric fields; an
// error or empty word stands alone; a stalled result port holds it on the waiting word.
// The converter reads the configuration registers all the while it works on a field, so
// they are written only while no field is loading or being converted; the block does not enforce this.
module ebcdic_field_to_ascii_text #(
   parameter int MAX_FIELD_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   e2a_req_if.sink    req_chan,
   e2a_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wr_data
);
   localparam int AW = $clog2(MAX_FIELD_BYTES);

   e2a_pkg::cfg_type       cfg_ff, cfg_in;
   e2a_pkg::fifo_stat_type q_stat;
   e2a_pkg::back_stat_type back_stat;
   e2a_pkg::job_type       push_job;
   e2a_pkg::job_type       head_job;
   logic                   push;
   logic                   ram_we;
   logic [AW:0]            ram_waddr;
   logic [7:0]             ram_wdata;
   logic [AW:0]            ram_raddr;
   logic [7:0]             ram_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            e2a_pkg::REG_FIELD_TYPE:  cfg_in.field_type  = csr_wr_data[1:0];
            e2a_pkg::REG_FIELD_BYTES: cfg_in.field_bytes = csr_wr_data;
            e2a_pkg::REG_PRECISION:   cfg_in.precision   = csr_wr_data[4:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.field_type  <= e2a_pkg::FT_ALPHA;
         cfg_ff.field_bytes <= 6'd1;
         cfg_ff.precision   <= 5'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   e2a_front #(
      .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .q_stat    (q_stat),
      .push      (push),
      .job       (push_job),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata)
   );

   e2a_bank_ram #(
      .DEPTH(2 << AW)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   e2a_job_fifo u_fifo (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (push_job),
      .pop    (back_stat.pop),
      .head   (head_job),
      .stat   (q_stat)
   );

   e2a_back #(
      .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head_job),
      .q_stat    (q_stat),
      .stat      (back_stat),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .rsp       (rsp_chan)
   );

   `E2A_ASSERT_IMPL(a_push_room, clock, reset, push, !q_stat.full)
   `E2A_ASSERT_IMPL(a_busy_has_job, clock, reset, back_stat.busy, !q_stat.empty)
   `E2A_ASSERT_IMPL(a_pop_has_job, clock, reset, back_stat.pop, !q_stat.empty)
   `E2A_ASSERT_NEXT(a_pop_then_idle, clock, reset, back_stat.pop, !back_stat.busy)
endmodule

// ----- hw/rtl/e2a_bank_ram.sv -----
`timescale 1ns / 1ps
module e2a_bank_ram #(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [7:0]               wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [7:0]               rdata
);
   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_data_ff <= mem_ff[raddr];
   end

   assign rdata = rd_data_ff;
endmodule

// ----- hw/rtl/e2a_job_fifo.sv -----
`timescale 1ns / 1ps
module e2a_job_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  e2a_pkg::job_type       job_in,
   input  logic                   pop,
   output e2a_pkg::job_type       head,
   output e2a_pkg::fifo_stat_type stat
);
   e2a_pkg::job_type entry_ff [2];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);
endmodule

// ----- hw/rtl/e2a_front.sv -----
`timescale 1ns / 1ps
module e2a_front #(
   parameter int MAX_FIELD_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   e2a_req_if.sink                             req,
   input  e2a_pkg::fifo_stat_type              q_stat,
   output logic                                push,
   output e2a_pkg::job_type                    job,
   output logic                                ram_we,
   output logic [$clog2(MAX_FIELD_BYTES):0]    ram_waddr,
   output logic [7:0]                          ram_wdata
);
   localparam int AW = $clog2(MAX_FIELD_BYTES);
   localparam logic [e2a_pkg::CNT_W-1:0] MAX_CNT = e2a_pkg::CNT_W'(MAX_FIELD_BYTES);

   logic                        bank_ff;
   logic [e2a_pkg::CNT_W-1:0]   count_ff;
   logic [e2a_pkg::CNT_W-1:0]   count_in;
   logic                        accept;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;

   // count saturates one past the store size
   assign count_in  = (count_ff <= MAX_CNT) ? count_ff + 1'b1 : count_ff;

   assign ram_we    = accept && (count_ff < MAX_CNT);
   assign ram_waddr = {bank_ff, count_ff[AW-1:0]};
   assign ram_wdata = req.data_byte;

   assign push      = accept && req.last_byte;
   assign job.bank  = bank_ff;
   assign job.count = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         if (req.last_byte) begin
            bank_ff  <= ~bank_ff;
            count_ff <= '0;
         end else begin
            count_ff <= count_in;
         end
      end
   end
endmodule

// ----- hw/rtl/e2a_back.sv -----
`timescale 1ns / 1ps
module e2a_back #(
   parameter int MAX_FIELD_BYTES = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  e2a_pkg::cfg_type                    cfg,
   input  e2a_pkg::job_type                    head,
   input  e2a_pkg::fifo_stat_type              q_stat,
   output e2a_pkg::back_stat_type              stat,
   output logic [$clog2(MAX_FIELD_BYTES):0]    ram_raddr,
   input  logic [7:0]                          ram_rdata,
   e2a_rsp_if.source                           rsp
);
   localparam int AW = $clog2(MAX_FIELD_BYTES);
   localparam int LW = ($clog2(MAX_FIELD_BYTES + 1) < 5) ? 5 : $clog2(MAX_FIELD_BYTES + 1);
   localparam int CW = e2a_pkg::CNT_W;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_SINGLE  = 4'd1;
   localparam logic [3:0] S_SIGN_RD = 4'd2;
   localparam logic [3:0] S_SIGN    = 4'd3;
   localparam logic [3:0] S_MINUS   = 4'd4;
   localparam logic [3:0] S_DRD     = 4'd5;
   localparam logic [3:0] S_DIG     = 4'd6;
   localparam logic [3:0] S_ZLAST   = 4'd7;
   localparam logic [3:0] S_TRIM_RD = 4'd8;
   localparam logic [3:0] S_TRIM    = 4'd9;
   localparam logic [3:0] S_TRD     = 4'd10;
   localparam logic [3:0] S_TXT     = 4'd11;

   logic [3:0]    state_ff, state_in;
   logic [LW-1:0] i_ff, i_in;
   logic [LW-1:0] len_ff, len_in;
   logic [LW-1:0] lead_ff, lead_in;
   logic [LW-1:0] t_ff, t_in;
   logic [5:0]    n_ff, n_in;
   logic          supp_ff, supp_in;
   logic          zdone_ff, zdone_in;
   logic          ddone_ff, ddone_in;
   logic          neg_ff, neg_in;
   logic [2:0]    status_ff, status_in;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_char_ff;
   logic          rsp_eot_ff;
   logic          rsp_empty_ff;
   logic [2:0]    rsp_status_ff;

   logic          slot_free;
   logic          emit_en, emit_nat, emit_last, emit_empty;
   logic [7:0]    emit_char;
   logic [2:0]    emit_status;
   logic          pop;
   logic          cap;

   logic          is_packed, is_num;
   logic [CW-1:0] fb_x, prec_x, len_x;
   logic          e_count, e_packed, e_stamp, e_prec;

   logic [LW-1:0] addr_pos;
   logic [LW-1:0] dig_pos;
   logic [AW-1:0] addr_idx;
   logic [3:0]    nib;
   logic [7:0]    dig_char;
   logic          i_last, is_zero, sign_neg;

   assign is_packed = (cfg.field_type == e2a_pkg::FT_PACKED);
   assign is_num    = is_packed || (cfg.field_type == e2a_pkg::FT_ZONED);
   assign fb_x      = CW'(cfg.field_bytes);
   assign prec_x    = CW'(cfg.precision);
   assign len_x     = is_packed ? ((fb_x << 1) - 1'b1) : fb_x;

   assign e_count  = (fb_x == '0) || (fb_x > CW'(MAX_FIELD_BYTES)) || (head.count != fb_x);
   assign e_packed = is_packed && (fb_x > CW'(e2a_pkg::PACKED_MAX_BYTES));
   assign e_stamp  = (cfg.field_type == e2a_pkg::FT_STAMP) &&
                     (fb_x != CW'(e2a_pkg::STAMP_BYTES));
   assign e_prec   = is_num && (prec_x > len_x);

   // read address: byte holding the digit position for numeric, byte position otherwise
   always_comb begin
      case (state_ff)
         S_SIGN_RD, S_SIGN: addr_pos = len_ff - 1'b1;
         S_TRIM_RD, S_TRIM: addr_pos = t_ff - 1'b1;
         default:           addr_pos = i_ff;
      endcase
   end

   assign dig_pos   = (is_num && is_packed) ? (addr_pos >> 1) : addr_pos;
   assign addr_idx  = AW'(dig_pos);
   assign ram_raddr = {head.bank, addr_idx};

   assign i_last   = (i_ff == len_ff - 1'b1);
   assign nib      = (is_packed && !i_ff[0]) ? ram_rdata[7:4] : ram_rdata[3:0];
   assign dig_char = e2a_pkg::ASCII_DIGIT | {4'h0, nib};
   assign is_zero  = is_packed ? ((nib == 4'h0) && !(neg_ff && i_last))
                               : (ram_rdata == e2a_pkg::ZONE_PLAIN);
   assign sign_neg = is_packed
      ? ((ram_rdata & e2a_pkg::NIBBLE_MASK) == e2a_pkg::SIGN_NEG)
      : ((ram_rdata & e2a_pkg::ZONE_MASK) == e2a_pkg::ZONE_NEG);

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign cap       = (n_ff == 6'(e2a_pkg::MAX_TEXT - 1));

   always_comb begin
      state_in    = state_ff;
      i_in        = i_ff;
      len_in      = len_ff;
      lead_in     = lead_ff;
      t_in        = t_ff;
      n_in        = n_ff;
      supp_in     = supp_ff;
      zdone_in    = zdone_ff;
      ddone_in    = ddone_ff;
      neg_in      = neg_ff;
      status_in   = status_ff;
      emit_en     = 1'b0;
      emit_nat    = 1'b0;
      emit_char   = 8'h00;
      emit_empty  = 1'b0;
      emit_status = e2a_pkg::ST_OK;
      pop         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (!q_stat.empty) begin
               i_in      = '0;
               n_in      = '0;
               supp_in   = 1'b1;
               zdone_in  = 1'b0;
               ddone_in  = 1'b0;
               neg_in    = 1'b0;
               len_in    = LW'(len_x);
               lead_in   = LW'(len_x - prec_x);
               t_in      = LW'(fb_x);
               status_in = e2a_pkg::ST_OK;
               if (e_count) begin
                  status_in = e2a_pkg::ST_COUNT;
                  state_in  = S_SINGLE;
               end else if (e_packed) begin
                  status_in = e2a_pkg::ST_PACKED;
                  state_in  = S_SINGLE;
               end else if (e_stamp) begin
                  status_in = e2a_pkg::ST_STAMP;
                  state_in  = S_SINGLE;
               end else if (e_prec) begin
                  status_in = e2a_pkg::ST_PREC;
                  state_in  = S_SINGLE;
               end else begin
                  case (cfg.field_type)
                     e2a_pkg::FT_PACKED, e2a_pkg::FT_ZONED: state_in = S_SIGN_RD;
                     e2a_pkg::FT_ALPHA:                     state_in = S_TRIM_RD;
                     default:                               state_in = S_TRD;
                  endcase
               end
            end
         end
         S_SINGLE: begin
            if (slot_free) begin
               emit_en     = 1'b1;
               emit_nat    = 1'b1;
               emit_empty  = 1'b1;
               emit_status = status_ff;
            end
         end
         S_SIGN_RD: state_in = S_SIGN;
         S_SIGN: begin
            neg_in   = sign_neg;
            state_in = sign_neg ? S_MINUS : S_DRD;
         end
         S_MINUS: begin
            if (slot_free) begin
               emit_en   = 1'b1;
               emit_char = e2a_pkg::CH_MINUS;
               state_in  = S_DRD;
            end
         end
         S_DRD: state_in = S_DIG;
         S_DIG: begin
            if (supp_ff && (i_ff < lead_ff) && is_zero) begin
               // leading zero dropped
               if (i_last) begin
                  state_in = S_ZLAST;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_DRD;
               end
            end else if (supp_ff && (i_ff == lead_ff) && !zdone_ff) begin
               if (slot_free) begin
                  emit_en   = 1'b1;
                  emit_char = e2a_pkg::CH_ZERO;
                  zdone_in  = 1'b1;
               end
            end else if ((i_ff == lead_ff) && !ddone_ff) begin
               if (slot_free) begin
                  emit_en   = 1'b1;
                  emit_char = e2a_pkg::CH_DOT;
                  ddone_in  = 1'b1;
               end
            end else if (slot_free) begin
               emit_en   = 1'b1;
               emit_char = dig_char;
               emit_nat  = i_last;
               supp_in   = 1'b0;
               i_in      = i_ff + 1'b1;
               state_in  = S_DRD;
            end
         end
         S_ZLAST: begin
            if (slot_free) begin
               emit_en   = 1'b1;
               emit_nat  = 1'b1;
               emit_char = e2a_pkg::CH_ZERO;
            end
         end
         S_TRIM_RD: state_in = S_TRIM;
         S_TRIM: begin
            if (ram_rdata == e2a_pkg::EBCDIC_BLANK) begin
               if (t_ff == LW'(1)) begin
                  status_in = e2a_pkg::ST_OK;
                  state_in  = S_SINGLE;
               end else begin
                  t_in     = t_ff - 1'b1;
                  state_in = S_TRIM_RD;
               end
            end else begin
               len_in   = t_ff;
               i_in     = '0;
               state_in = S_TRD;
            end
         end
         S_TRD: state_in = S_TXT;
         S_TXT: begin
            if (slot_free) begin
               emit_en   = 1'b1;
               emit_char = e2a_pkg::LATIN1_OF[ram_rdata];
               emit_nat  = i_last;
               i_in      = i_ff + 1'b1;
               state_in  = S_TRD;
            end
         end
         default: state_in = S_IDLE;
      endcase

      emit_last = emit_en && (emit_nat || cap);
      if (emit_en) begin
         n_in = n_ff + 6'd1;
      end
      if (emit_last) begin
         pop      = 1'b1;
         state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      len_ff    <= len_in;
      lead_ff   <= lead_in;
      t_ff      <= t_in;
      n_ff      <= n_in;
      supp_ff   <= supp_in;
      zdone_ff  <= zdone_in;
      ddone_ff  <= ddone_in;
      neg_ff    <= neg_in;
      status_ff <= status_in;
      if (emit_en) begin
         rsp_char_ff   <= emit_char;
         rsp_eot_ff    <= emit_last;
         rsp_empty_ff  <= emit_empty;
         rsp_status_ff <= emit_status;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit_en) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_char    = rsp_char_ff;
   assign rsp.end_of_text = rsp_eot_ff;
   assign rsp.empty_text  = rsp_empty_ff;
   assign rsp.status      = rsp_status_ff;

   assign stat.busy = (state_ff != S_IDLE);
   assign stat.pop  = pop;
endmodule
